// ===== rtl/psfc_pkg.sv =====
package psfc_pkg;

	// sample format codes, shared by both format registers
	typedef enum logic [1:0] {
		FMT_PCM16    = 2'd0,
		FMT_PCM24_32 = 2'd1,
		FMT_PCM32_LJ = 2'd2,
		FMT_PACK24   = 2'd3
	} fmt_t;

	// configuration register indexes
	localparam int CFG_IDX_BITS = 2;
	localparam logic [CFG_IDX_BITS-1:0] REG_SRC_FMT  = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_DST_FMT  = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_CAPACITY = 2'd2;

	localparam int COUNT_BITS_DEF = 32;
	localparam int QUEUE_DEPTH_DEF = 4;

	// one queued item: the bytes of a sample and/or an end-of-buffer report
	typedef struct packed {
		logic [31:0] word;
		logic [2:0]  nbytes;
		logic        done;
		logic [31:0] count;
	} psfc_item_t;

	// bytes per sample for each format
	function automatic logic [2:0] fmt_size(input fmt_t f);
		logic [2:0] s;
		unique case (f)
			FMT_PCM16:    s = 3'd2;
			FMT_PCM24_32: s = 3'd4;
			FMT_PCM32_LJ: s = 3'd4;
			FMT_PACK24:   s = 3'd3;
		endcase
		return s;
	endfunction

	// raw little-endian container to 24-bit sample
	function automatic logic [23:0] decode24(input logic [31:0] raw, input fmt_t f);
		logic [23:0] s;
		unique case (f)
			FMT_PCM16:    s = {raw[15:0], 8'h00};
			FMT_PCM24_32: s = raw[23:0];
			FMT_PCM32_LJ: s = raw[31:8];
			FMT_PACK24:   s = raw[23:0];
		endcase
		return s;
	endfunction

	// 24-bit sample to destination container
	function automatic logic [31:0] encode(input logic [23:0] s, input fmt_t f);
		logic [31:0] w;
		unique case (f)
			FMT_PCM16:    w = {16'h0000, s[23:8]};
			FMT_PCM24_32: w = {8'h00, s};
			FMT_PCM32_LJ: w = {s, 8'h00};
			FMT_PACK24:   w = {8'h00, s};
		endcase
		return w;
	endfunction

endpackage

// ===== rtl/psfc_front.sv =====
module psfc_front import psfc_pkg::*; #(
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	// configuration
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  logic [31:0]             cfg_data,
	// source bytes
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [7:0]              in_byte,
	input  logic                    end_of_buffer,
	// queue side
	input  logic                    q_full,
	output logic                    q_push,
	output psfc_item_t              q_item
);

	fmt_t                  src_fmt_q, dst_fmt_q;
	logic [31:0]           capacity_q;
	logic [31:0]           sbytes_q;
	logic [1:0]            pos_q;
	logic [31:0]           bw_q;
	logic [COUNT_BITS-1:0] cnt_q;
	logic                  stopped_q;

	logic                  in_fire;
	logic [31:0]           assembled;
	logic [2:0]            src_size, dst_size;
	logic                  complete, fits, emit;
	logic [32:0]           bw_sum;
	logic [31:0]           word;
	logic [COUNT_BITS-1:0] cnt_inc;

	assign cfg_ready = 1'b1;
	assign in_stall  = q_full;
	assign in_fire   = in_valid && !in_stall;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_fmt_q  <= FMT_PCM16;
			dst_fmt_q  <= FMT_PCM16;
			capacity_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_SRC_FMT:  src_fmt_q  <= fmt_t'(cfg_data[1:0]);
				REG_DST_FMT:  dst_fmt_q  <= fmt_t'(cfg_data[1:0]);
				REG_CAPACITY: capacity_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// assemble the sample and check it against the capacity
	always_comb begin
		assembled = sbytes_q | ({24'h0, in_byte} << {pos_q, 3'b000});
		src_size  = fmt_size(src_fmt_q);
		dst_size  = fmt_size(dst_fmt_q);
		complete  = ({1'b0, pos_q} + 3'd1) >= src_size;
		bw_sum    = {1'b0, bw_q} + {30'h0, dst_size};
		fits      = bw_sum <= {1'b0, capacity_q};
		emit      = !stopped_q && complete && fits;
		cnt_inc   = cnt_q + COUNT_BITS'(1);
		if (src_fmt_q == dst_fmt_q)
			word = assembled;
		else
			word = encode(decode24(assembled, src_fmt_q), dst_fmt_q);
	end

	// item into the queue
	always_comb begin
		q_push        = in_fire && (emit || end_of_buffer);
		q_item.word   = word;
		q_item.nbytes = emit ? dst_size : 3'd0;
		q_item.done   = end_of_buffer;
		q_item.count  = emit ? 32'(cnt_inc) : 32'(cnt_q);
	end

	// per-buffer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sbytes_q  <= '0;
			pos_q     <= '0;
			bw_q      <= '0;
			cnt_q     <= '0;
			stopped_q <= 1'b0;
		end else if (in_fire) begin
			if (end_of_buffer) begin
				sbytes_q  <= '0;
				pos_q     <= '0;
				bw_q      <= '0;
				cnt_q     <= '0;
				stopped_q <= 1'b0;
			end else if (!stopped_q) begin
				if (complete) begin
					sbytes_q <= '0;
					pos_q    <= '0;
					if (fits) begin
						bw_q  <= bw_sum[31:0];
						cnt_q <= cnt_inc;
					end else begin
						stopped_q <= 1'b1;
					end
				end else begin
					sbytes_q <= assembled;
					pos_q    <= pos_q + 2'd1;
				end
			end
		end
	end

`ifndef NO_ASSERTIONS
	// a stopped buffer holds no partial sample
	a_stop_clear: assert property (@(posedge clk) disable iff (!arst_n)
		stopped_q |-> (pos_q == 2'd0 && sbytes_q == 32'h0))
		else $error("partial sample held while stopped");
	// written bytes never pass the capacity
	a_cap: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && emit |=> bw_q <= capacity_q)
		else $error("capacity exceeded");
	// end of buffer returns the state to zero
	a_eob: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && end_of_buffer |=> (bw_q == 32'h0 && !stopped_q && pos_q == 2'd0))
		else $error("state not cleared after end of buffer");
`endif

endmodule

// ===== rtl/psfc_queue.sv =====
module psfc_queue import psfc_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  psfc_item_t push_item,
	output logic       full,
	input  logic       pop,
	output logic       empty,
	output psfc_item_t pop_item
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	psfc_item_t      mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]   count_q;

	assign full     = count_q == CW'(DEPTH);
	assign empty    = count_q == '0;
	assign pop_item = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push && !full)
			mem_q[wr_ptr_q] <= push_item;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push && !full)
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			if (pop && !empty)
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			if ((push && !full) && !(pop && !empty))
				count_q <= count_q + CW'(1);
			else if (!(push && !full) && (pop && !empty))
				count_q <= count_q - CW'(1);
		end
	end

`ifndef NO_ASSERTIONS
	a_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("queue overfilled");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("pop from empty queue");
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("push into full queue");
`endif

endmodule

// ===== rtl/psfc_back.sv =====
module psfc_back import psfc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// queue side
	input  logic        q_empty,
	input  psfc_item_t  q_item,
	output logic        q_pop,
	// results
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_byte,
	output logic        byte_valid,
	output logic        done_res,
	output logic [31:0] samples_done,
	output logic        run_last
);

	logic        busy_q;
	logic [31:0] word_q;
	logic [2:0]  nbytes_q;
	logic        done_q;
	logic [31:0] count_q;
	logic [2:0]  idx_q;

	logic        out_fire, byte_phase, last;
	logic [31:0] shifted;

	assign out_valid = busy_q;
	assign out_fire  = out_valid && !out_stall;

	// current result from the held item
	always_comb begin
		byte_phase   = idx_q < nbytes_q;
		last         = done_q ? (idx_q == nbytes_q) : (idx_q == nbytes_q - 3'd1);
		shifted      = word_q >> {idx_q[1:0], 3'b000};
		out_byte     = byte_phase ? shifted[7:0] : 8'h00;
		byte_valid   = byte_phase;
		done_res     = !byte_phase;
		samples_done = byte_phase ? 32'h0 : count_q;
		run_last     = last;
	end

	// load the next item once the current one is finished
	assign q_pop = !q_empty && (!busy_q || (out_fire && last));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (q_pop) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (out_fire) begin
			if (last)
				busy_q <= 1'b0;
			else
				idx_q <= idx_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			word_q   <= q_item.word;
			nbytes_q <= q_item.nbytes;
			done_q   <= q_item.done;
			count_q  <= q_item.count;
		end
	end

`ifndef NO_ASSERTIONS
	// the index never runs past the item's results
	a_idx: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> idx_q <= nbytes_q)
		else $error("result index out of range");
	// every held item gives at least one result
	a_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (done_q || nbytes_q != 3'd0))
		else $error("held item with no results");
	// after the last result with nothing queued the back goes idle
	a_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_fire && last && q_empty |=> !busy_q)
		else $error("back stayed busy after last result");
`endif

endmodule

// ===== rtl/pcm_sample_format_converter_top.sv =====
// PCM sample format converter. Source bytes enter one per cycle on the input
// channel while in_stall is low and are assembled into little-endian samples
// (pcm16, 24-in-32, 32 left-justified, packed 24); each whole sample that fits
// in dest_capacity leaves as 2, 3 or 4 destination bytes, one per cycle while
// out_stall is low, and a byte carrying end_of_buffer adds a done result with
// the count of samples written. The front accepts a byte every cycle as long as
// its four-entry item queue has room; the back sends one result per cycle while
// out_stall is low, so where a sample gives more results than source bytes the
// output port sets sustained throughput. An input reaches the output through
// the item queue and the back's held-item registers.
// Write configuration only while the block is idle.
module pcm_sample_format_converter_top import psfc_pkg::*; #(
	parameter int COUNT_BITS  = COUNT_BITS_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  logic [31:0]             cfg_data,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [7:0]              in_byte,
	input  logic                    end_of_buffer,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [7:0]              out_byte,
	output logic                    byte_valid,
	output logic                    done_res,
	output logic [31:0]             samples_done,
	output logic                    run_last
);

	logic       q_full, q_push, q_empty, q_pop;
	psfc_item_t push_item, pop_item;

	psfc_front #(.COUNT_BITS(COUNT_BITS)) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.in_byte       (in_byte),
		.end_of_buffer (end_of_buffer),
		.q_full        (q_full),
		.q_push        (q_push),
		.q_item        (push_item)
	);

	psfc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (q_pop),
		.empty     (q_empty),
		.pop_item  (pop_item)
	);

	psfc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_empty      (q_empty),
		.q_item       (pop_item),
		.q_pop        (q_pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_byte     (out_byte),
		.byte_valid   (byte_valid),
		.done_res     (done_res),
		.samples_done (samples_done),
		.run_last     (run_last)
	);

endmodule

// ===== tb/tb_pcm_sample_format_converter_top.sv =====
module tb_pcm_sample_format_converter_top;
	import psfc_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 12;
	localparam int PRESS_CYCLES = 80;
	localparam int RAND_ITEMS   = 150;

	typedef struct {
		logic [7:0] data;
		logic       eob;
	} src_item_t;

	typedef struct {
		logic [7:0]  out_byte;
		logic        byte_valid;
		logic        done_res;
		logic [31:0] samples_done;
		logic        run_last;
	} out_item_t;

	// DUT ports
	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    cfg_valid = 1'b0;
	logic                    cfg_ready;
	logic [CFG_IDX_BITS-1:0] cfg_index = '0;
	logic [31:0]             cfg_data = '0;
	logic                    in_valid = 1'b0;
	logic                    in_stall;
	logic [7:0]              in_byte = '0;
	logic                    end_of_buffer = 1'b0;
	logic                    out_valid;
	logic                    out_stall = 1'b0;
	logic [7:0]              out_byte;
	logic                    byte_valid;
	logic                    done_res;
	logic [31:0]             samples_done;
	logic                    run_last;

	// stimulus and expectation stores
	src_item_t src_bytes_q[$];
	out_item_t expected_out_q[$];
	out_item_t want_res;

	// converter state mirror
	fmt_t        src_fmt = FMT_PCM16;
	fmt_t        dst_fmt = FMT_PCM16;
	logic [31:0] dest_cap = '0;
	logic [31:0] acc_word = '0;
	logic [1:0]  acc_pos = '0;
	logic [63:0] wr_total = '0;
	logic [31:0] smp_cnt = '0;
	logic        halted = 1'b0;

	// handshake bookkeeping
	logic held = 1'b0;
	logic in_fire = 1'b0;
	int   in_gap = 0;
	logic press_req = 1'b0;
	int   press_left = 0;
	int   stall_left = 0;
	int   go_left = 0;
	int   err_cnt = 0;
	int   cyc_cnt = 0;

	pcm_sample_format_converter_top DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.in_byte      (in_byte),
		.end_of_buffer(end_of_buffer),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_byte     (out_byte),
		.byte_valid   (byte_valid),
		.done_res     (done_res),
		.samples_done (samples_done),
		.run_last     (run_last)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic int bytes_of(input fmt_t f);
		int n;
		case (f)
			FMT_PCM16:  n = 2;
			FMT_PACK24: n = 3;
			default:    n = 4;
		endcase
		return n;
	endfunction

	// container-to-container conversion through a 24-bit sample
	function automatic logic [31:0] remap(input logic [31:0] raw, input fmt_t sf, input fmt_t df);
		logic [23:0] s;
		logic [31:0] w;
		if (sf == df)
			return raw;
		case (sf)
			FMT_PCM16:    s = {raw[15:0], 8'h00};
			FMT_PCM32_LJ: s = raw[31:8];
			default:      s = raw[23:0];
		endcase
		case (df)
			FMT_PCM16:    w = {16'h0000, s[23:8]};
			FMT_PCM32_LJ: w = {s, 8'h00};
			default:      w = {8'h00, s};
		endcase
		return w;
	endfunction

	// expected results for one accepted source byte
	task automatic predict_conversion(input logic [7:0] b, input logic eob);
		out_item_t   res[5];
		logic [31:0] word;
		int          n;
		int          ssz;
		int          dsz;
		n = 0;
		ssz = bytes_of(src_fmt);
		dsz = bytes_of(dst_fmt);
		if (!halted) begin
			acc_word = acc_word | (32'(b) << (8 * acc_pos));
			if (int'(acc_pos) + 1 >= ssz) begin
				word = acc_word;
				acc_word = '0;
				acc_pos = '0;
				if (wr_total + 64'(dsz) > 64'(dest_cap)) begin
					halted = 1'b1;
				end else begin
					word = remap(word, src_fmt, dst_fmt);
					for (int i = 0; i < dsz; i++) begin
						res[n] = '{out_byte: word[8*i +: 8], byte_valid: 1'b1, done_res: 1'b0,
							samples_done: 32'h0, run_last: 1'b0};
						n++;
					end
					wr_total = wr_total + 64'(dsz);
					smp_cnt = smp_cnt + 32'd1;
				end
			end else begin
				acc_pos = acc_pos + 2'd1;
			end
		end
		// end of buffer: done report, then back to a clean buffer
		if (eob) begin
			res[n] = '{out_byte: 8'h00, byte_valid: 1'b0, done_res: 1'b1,
				samples_done: smp_cnt, run_last: 1'b0};
			n++;
			acc_word = '0;
			acc_pos = '0;
			wr_total = '0;
			smp_cnt = '0;
			halted = 1'b0;
		end
		for (int i = 0; i < n; i++) begin
			res[i].run_last = (i == n - 1);
			expected_out_q.push_back(res[i]);
		end
	endtask

	task automatic report_error(input string msg);
		$display("ERROR @%0t: %s", $realtime, msg);
		err_cnt++;
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic logic [7:0] pick_byte();
		logic [7:0] v;
		case ($urandom_range(0, 7))
			0:       v = 8'h00;
			1:       v = 8'hff;
			2:       v = 8'h80;
			3:       v = 8'h7f;
			default: v = 8'($urandom_range(0, 255));
		endcase
		return v;
	endfunction

	task automatic queue_byte(input logic [7:0] b, input logic eob);
		src_item_t it;
		it.data = b;
		it.eob = eob;
		src_bytes_q.push_back(it);
	endtask

	// register write, mirrored into the predictor on acceptance
	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [31:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_SRC_FMT:  src_fmt = fmt_t'(val[1:0]);
			REG_DST_FMT:  dst_fmt = fmt_t'(val[1:0]);
			REG_CAPACITY: dest_cap = val;
			default:      ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic write_fmt(input logic [CFG_IDX_BITS-1:0] idx, input fmt_t f);
		logic [31:0] w;
		w = $urandom();
		w[1:0] = f;
		write_reg(idx, w);
	endtask

	// block drained: nothing queued, nothing in flight
	task automatic wait_idle();
		while (src_bytes_q.size() != 0 || held || expected_out_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// source byte driver
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_fire) begin
				in_fire = 1'b0;
				src_bytes_q.delete(0);
				held = 1'b0;
				in_gap = (press_left > 0) ? 0 : pick_gap();
			end
			if (!held) begin
				if (in_gap > 0)
					in_gap--;
				else if (src_bytes_q.size() != 0)
					held = 1'b1;
			end
			in_valid <= held;
			if (held) begin
				in_byte <= src_bytes_q[0].data;
				end_of_buffer <= src_bytes_q[0].eob;
			end
		end
	end

	// result receiver stalls, with a long hold-off on request
	always @(negedge clk) begin
		if (press_req) begin
			press_req = 1'b0;
			press_left = PRESS_CYCLES;
		end
		if (press_left > 0) begin
			press_left--;
			out_stall <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else if (go_left > 0) begin
			go_left--;
			out_stall <= 1'b0;
		end else begin
			go_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 80) : $urandom_range(0, 6);
			stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(15, 40) : $urandom_range(0, 3);
			out_stall <= 1'b0;
		end
	end

	// accept tracking, prediction and result checking
	always @(posedge clk) begin
		if (arst_n) begin
			cyc_cnt++;
			if (cyc_cnt > CYCLE_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end else begin
				if (in_valid && !in_stall) begin
					predict_conversion(in_byte, end_of_buffer);
					in_fire = 1'b1;
				end
				if (out_valid && !out_stall) begin
					if (expected_out_q.size() == 0) begin
						report_error($sformatf("unexpected result byte %02h v%0b d%0b n%0d l%0b",
							out_byte, byte_valid, done_res, samples_done, run_last));
					end else begin
						want_res = expected_out_q.pop_front();
						if (out_byte !== want_res.out_byte || byte_valid !== want_res.byte_valid ||
							done_res !== want_res.done_res ||
							samples_done !== want_res.samples_done ||
							run_last !== want_res.run_last)
							report_error($sformatf(
								"got byte %02h v%0b d%0b n%0d l%0b, want byte %02h v%0b d%0b n%0d l%0b",
								out_byte, byte_valid, done_res, samples_done, run_last,
								want_res.out_byte, want_res.byte_valid, want_res.done_res,
								want_res.samples_done, want_res.run_last));
					end
				end
			end
		end
	end

	initial begin
		fmt_t        s_f;
		fmt_t        d_f;
		logic [31:0] cap;
		int          dsz;
		int          ssz;
		int          nbuf;
		int          nsamp;
		int          nbytes;
		int          rand_items;
		int          phase;

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset config: zero capacity, first sample stops the buffer
		queue_byte(8'h00, 1'b0);
		queue_byte(8'hff, 1'b1);
		wait_idle();

		// pcm16 expanded to left-justified 32
		write_reg(REG_CAPACITY, 32'hffffffff);
		write_fmt(REG_SRC_FMT, FMT_PCM16);
		write_fmt(REG_DST_FMT, FMT_PCM32_LJ);
		queue_byte(8'hff, 1'b0);
		queue_byte(8'h80, 1'b0);
		queue_byte(8'h01, 1'b0);
		queue_byte(8'h7f, 1'b1);
		wait_idle();

		// 24-in-32 with junk top byte to packed 24, trailing partial byte dropped
		write_fmt(REG_SRC_FMT, FMT_PCM24_32);
		write_fmt(REG_DST_FMT, FMT_PACK24);
		queue_byte(8'h56, 1'b0);
		queue_byte(8'h34, 1'b0);
		queue_byte(8'h92, 1'b0);
		queue_byte(8'hab, 1'b0);
		queue_byte(8'h5a, 1'b1);
		wait_idle();

		// left-justified 32 down to pcm16
		write_fmt(REG_SRC_FMT, FMT_PCM32_LJ);
		write_fmt(REG_DST_FMT, FMT_PCM16);
		queue_byte(8'h11, 1'b0);
		queue_byte(8'h80, 1'b0);
		queue_byte(8'hff, 1'b0);
		queue_byte(8'h7f, 1'b1);
		wait_idle();

		// equal formats: straight copy, top byte kept
		write_fmt(REG_SRC_FMT, FMT_PCM24_32);
		write_fmt(REG_DST_FMT, FMT_PCM24_32);
		queue_byte(8'h01, 1'b0);
		queue_byte(8'h02, 1'b0);
		queue_byte(8'h83, 1'b0);
		queue_byte(8'haa, 1'b1);
		wait_idle();

		// source format switched mid-sample, then capacity runs out
		write_fmt(REG_SRC_FMT, FMT_PACK24);
		write_reg(REG_CAPACITY, 32'd4);
		queue_byte(8'hc3, 1'b0);
		wait_idle();
		write_fmt(REG_SRC_FMT, FMT_PCM16);
		queue_byte(8'h81, 1'b0);
		queue_byte(8'h11, 1'b0);
		queue_byte(8'h22, 1'b0);
		queue_byte(8'h33, 1'b0);
		queue_byte(8'h44, 1'b1);
		wait_idle();

		// random phases: mostly whole-sample buffers, some partial or unterminated
		rand_items = 0;
		phase = 0;
		while (rand_items < RAND_ITEMS || phase <= 2) begin
			s_f = fmt_t'($urandom_range(0, 3));
			d_f = fmt_t'($urandom_range(0, 3));
			ssz = bytes_of(s_f);
			dsz = bytes_of(d_f);
			case ($urandom_range(0, 7))
				0:       cap = 32'h0;
				1:       cap = 32'hffffffff;
				2, 3:    cap = 32'(dsz * $urandom_range(0, 5));
				4:       cap = 32'(dsz * $urandom_range(1, 5) + $urandom_range(1, dsz - 1));
				default: cap = 32'($urandom_range(8, 64));
			endcase
			if (phase == 2)
				cap = 32'hffffffff;
			wait_idle();
			write_fmt(REG_SRC_FMT, s_f);
			write_fmt(REG_DST_FMT, d_f);
			write_reg(REG_CAPACITY, cap);
			if (phase == 2)
				press_req = 1'b1;
			nbuf = $urandom_range(1, 3);
			for (int bi = 0; bi < nbuf; bi++) begin
				nsamp = (phase == 2) ? 10 : $urandom_range(0, 6);
				nbytes = nsamp * ssz;
				if (nbytes == 0 || $urandom_range(0, 3) == 0)
					nbytes += $urandom_range(1, ssz - 1);
				for (int k = 0; k < nbytes; k++)
					queue_byte(pick_byte(), (k == nbytes - 1) && ($urandom_range(0, 7) != 0));
				rand_items += nbytes;
			end
			phase++;
		end

		wait_idle();
		if (expected_out_q.size() != 0)
			report_error($sformatf("%0d results never arrived", expected_out_q.size()));
		if (err_cnt == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
